[hw/rtl/base64_codec_assert.svh]
// Assertion macros used by the base64 codec checker.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BASE64_CODEC_ASSERT_SVH
`define BASE64_CODEC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/b64_pkg.sv]
// Shared types, constants and alphabet functions for the base64 codec.
// No dependencies; b64_step, base64_codec and b64_checker import this package.
package b64_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic       MODE_ENCODE = 1'b0;
  localparam logic       MODE_DECODE = 1'b1;
  localparam int         MAX_RES     = 4;

  // One result record as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       bad;
  } b64_res_t;

  // All results caused by one input item.
  typedef struct packed {
    logic [2:0]                 cnt;
    b64_res_t [MAX_RES-1:0]     res;
  } b64_group_t;

  // Group state carried from one item to the next.
  typedef struct packed {
    logic [1:0] pos;
    logic [5:0] held;
    logic       pad;
  } b64_state_t;

  // Map a 6-bit value to its alphabet character.
  function automatic logic [7:0] enc6(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      return 8'h41 + w;
    else if (v < 6'd52) return w + 8'd71;
    else if (v < 6'd62) return w - 8'd4;
    else if (v == 6'd62) return 8'h2B;
    else                return 8'h2F;
  endfunction

  // Map a character to {in_alphabet, 6-bit value}; value is 0 when outside.
  function automatic logic [6:0] dec8(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
      return {1'b1, t[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'd71;
      return {1'b1, t[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c + 8'd4;
      return {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

[hw/rtl/b64_if.sv]
// Valid/ready stream interfaces for the input and result channels of the codec.
// No dependencies.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       stream_last;

  modport source (output valid, data_in, stream_last, input ready);
  modport sink   (input valid, data_in, stream_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       has_data;
  logic       run_last;
  logic       stream_end;
  logic       bad_input;

  modport source (output valid, data_out, has_data, run_last, stream_end, bad_input,
                  input ready);
  modport sink   (input valid, data_out, has_data, run_last, stream_end, bad_input,
                  output ready);
endinterface

[hw/rtl/b64_step.sv]
// Combinational step of the codec: one item plus group state gives results and new state.
// Depends on b64_pkg.
module b64_step (
  input  logic               mode,
  input  b64_pkg::b64_state_t st,
  input  logic [7:0]         data_in,
  input  logic               stream_last,
  output b64_pkg::b64_group_t grp,
  output b64_pkg::b64_state_t st_nxt
);
  import b64_pkg::*;

  logic [6:0] look;
  logic       in_alpha;
  logic [5:0] val;
  logic       is_pad;
  logic       bad;
  logic       has;
  logic [7:0] byte_out;
  logic [1:0] pos_inc;

  // Alphabet lookup for decoding.
  assign look     = dec8(data_in);
  assign in_alpha = look[6];
  assign val      = look[5:0];
  assign is_pad   = (data_in == PAD_CHAR) && st.pos[1];
  assign pos_inc  = st.pos + 2'd1;

  always_comb begin
    grp      = '0;
    st_nxt   = st;
    bad      = 1'b0;
    has      = 1'b0;
    byte_out = 8'd0;
    if (mode == MODE_ENCODE) begin
      // Emit completed 6-bit groups, then flush and pad on the final byte.
      case (st.pos)
        2'd1: begin
          grp.res[0] = '{data: enc6({st.held[1:0], data_in[7:4]}), has: 1'b1, bad: 1'b0};
          grp.cnt    = 3'd1;
          if (stream_last) begin
            grp.res[1] = '{data: enc6({data_in[3:0], 2'b00}), has: 1'b1, bad: 1'b0};
            grp.res[2] = '{data: PAD_CHAR, has: 1'b1, bad: 1'b0};
            grp.cnt    = 3'd3;
            st_nxt     = '0;
          end else begin
            st_nxt.held = {2'b00, data_in[3:0]};
            st_nxt.pos  = 2'd2;
          end
        end
        2'd2: begin
          grp.res[0] = '{data: enc6({st.held[3:0], data_in[7:6]}), has: 1'b1, bad: 1'b0};
          grp.res[1] = '{data: enc6(data_in[5:0]), has: 1'b1, bad: 1'b0};
          grp.cnt    = 3'd2;
          st_nxt.held = 6'd0;
          st_nxt.pos  = 2'd0;
          if (stream_last) begin
            st_nxt = '0;
          end
        end
        default: begin
          grp.res[0] = '{data: enc6(data_in[7:2]), has: 1'b1, bad: 1'b0};
          grp.cnt    = 3'd1;
          if (stream_last) begin
            grp.res[1] = '{data: enc6({data_in[1:0], 4'b0000}), has: 1'b1, bad: 1'b0};
            grp.res[2] = '{data: PAD_CHAR, has: 1'b1, bad: 1'b0};
            grp.res[3] = '{data: PAD_CHAR, has: 1'b1, bad: 1'b0};
            grp.cnt    = 3'd4;
            st_nxt     = '0;
          end else begin
            st_nxt.held = {4'b0000, data_in[1:0]};
            st_nxt.pos  = 2'd1;
          end
        end
      endcase
    end else begin
      // Decode one character; a byte completes at positions 1, 2 and 3.
      bad = !in_alpha && !is_pad;
      case (st.pos)
        2'd0: begin
          st_nxt.held = val;
        end
        2'd1: begin
          byte_out    = {st.held, val[5:4]};
          has         = 1'b1;
          st_nxt.held = {2'b00, val[3:0]};
        end
        2'd2: begin
          if (is_pad) begin
            st_nxt.pad  = 1'b1;
            st_nxt.held = 6'd0;
          end else begin
            byte_out    = {st.held[3:0], val[5:2]};
            has         = 1'b1;
            st_nxt.held = {4'b0000, val[1:0]};
          end
        end
        default: begin
          if (!is_pad) begin
            if (st.pad) begin
              bad = 1'b1;
            end else begin
              byte_out = {st.held[1:0], val};
              has      = 1'b1;
            end
          end
          st_nxt.held = 6'd0;
        end
      endcase
      // A string must end on the last character of a group.
      if (stream_last && (st.pos != 2'd3)) begin
        bad = 1'b1;
      end
      st_nxt.pos = pos_inc;
      if (pos_inc == 2'd0) begin
        st_nxt.pad = 1'b0;
      end
      if (stream_last) begin
        st_nxt = '0;
      end
      grp.res[0] = '{data: byte_out, has: has, bad: bad};
      grp.cnt    = (has || bad || stream_last) ? 3'd1 : 3'd0;
    end
  end

endmodule

[hw/rtl/base64_codec.sv]
// Top level of the streaming base64 codec (standard alphabet, '=' padding).
// Depends on b64_pkg, b64_if and b64_step.
//
// The mode register selects encoding (0) or decoding (1); writing it restarts the current
// group, so write it only between strings. Each accepted item is processed in the cycle of
// its transfer and its results land in a four-entry result register, which the output
// channel drains one result per cycle while out_ch.ready is high; a new item is taken in
// the cycle the last result of the previous one goes out. Decoding thus runs at one
// character per cycle while the output does not stall. Encoding is limited by the single
// result port, which carries one output character per result: a byte is taken only as the
// last character of the previous byte goes out, and the final byte also flushes and pads.
// bad_input flags, when decoding, a character outside the alphabet (decoded as 0), a
// misplaced '=', data after a pad, and a string that ends off a group boundary.
module base64_codec (
  input  logic          clk,
  input  logic          rst_n,
  b64_in_if.sink        in_ch,
  b64_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import b64_pkg::*;

  logic        mode_r;
  b64_state_t  st_r;
  b64_state_t  st_nxt;
  b64_group_t  grp;
  b64_group_t  buf_r;
  logic [1:0]  idx_r;
  logic        full_r;
  logic        last_r;
  logic        in_xfer;
  logic        out_xfer;
  logic        at_final;
  b64_res_t    cur;

  b64_step u_step (
    .mode        (mode_r),
    .st          (st_r),
    .data_in     (in_ch.data_in),
    .stream_last (in_ch.stream_last),
    .grp         (grp),
    .st_nxt      (st_nxt)
  );

  // Result register read-out, one entry per transfer.
  assign cur      = buf_r.res[idx_r];
  assign at_final = (({1'b0, idx_r} + 3'd1) == buf_r.cnt);
  assign out_xfer = full_r && out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign in_ch.ready       = !full_r || (out_ch.ready && at_final);
  assign out_ch.valid      = full_r;
  assign out_ch.data_out   = cur.data;
  assign out_ch.has_data   = cur.has;
  assign out_ch.bad_input  = cur.bad;
  assign out_ch.run_last   = at_final;
  assign out_ch.stream_end = at_final && last_r;

  // Mode register and group state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      st_r   <= '0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      st_r   <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (in_xfer) begin
      full_r <= (grp.cnt != 3'd0);
      idx_r  <= 2'd0;
    end else if (out_xfer) begin
      if (at_final) begin
        full_r <= 1'b0;
      end
      idx_r <= idx_r + 2'd1;
    end
  end

  // Result payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      buf_r  <= grp;
      last_r <= in_ch.stream_last;
    end
  end

endmodule

[hw/rtl/b64_checker.sv]
// Port-level checker for the base64 codec, bound to the top level.
// Depends on b64_pkg and base64_codec_assert.svh.
`include "base64_codec_assert.svh"

module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic       cfg_wdata,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       out_has,
  input logic       out_run_last,
  input logic       out_stream_end,
  input logic       out_bad
);
  import b64_pkg::*;

  logic mode_r;

  // Track the mode from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  `B64_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(out_bad), "result changed while stalled")
  `B64_ASSERT_IMP(a_end_is_final, out_valid && out_stream_end, out_run_last, "stream end on a result that is not final for its item")
  `B64_ASSERT_IMP(a_enc_no_bad, out_valid && (mode_r == MODE_ENCODE), !out_bad && out_has, "encode result without data or flagged bad")
  `B64_ASSERT_IMP(a_dec_single, out_valid && (mode_r == MODE_DECODE), out_run_last && (out_has || out_data == 8'd0), "decode result not single or marker not zero")

endmodule

bind base64_codec b64_checker u_b64_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_we         (cfg_we),
  .cfg_wdata      (cfg_wdata),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data       (out_ch.data_out),
  .out_has        (out_ch.has_data),
  .out_run_last   (out_ch.run_last),
  .out_stream_end (out_ch.stream_end),
  .out_bad        (out_ch.bad_input)
);
